### hw/rtl/assert_macros.svh
// Assertion helpers clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DRFP_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define DRFP_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### hw/rtl/drfp_pkg.sv
package drfp_pkg;

    localparam logic [7:0] HEADER_FIRST_RESET  = 8'h5A;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'hA5;

    localparam logic [7:0] CMD_REG_READ = 8'h81;
    localparam logic [7:0] CMD_VAR_READ = 8'h83;

    localparam int unsigned CFG_COUNT       = 2;
    localparam int unsigned CFG_INDEX_WIDTH = 1;
    localparam int unsigned CFG_DATA_WIDTH  = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HEADER_FIRST  = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HEADER_SECOND = 1'd1;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_beat_t;

    typedef struct packed {
        logic        reply_kind;
        logic [15:0] start_address;
        logic [7:0]  element_index;
        logic [15:0] element_value;
        logic        last_element;
    } reply_beat_t;

endpackage

### hw/rtl/drfp_stream_if.sv
interface drfp_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/display_reply_frame_parser_unit.sv
// Receive-side frame parser for a serial display link.
// rx (sink, payload rx_byte) takes one received byte per beat. Frames are
// header_first, header_second, length, command, then the body. Command 0x81
// carries an 8-bit start register and a count, then one byte per element;
// command 0x83 carries a 16-bit big-endian address and a count, then one
// big-endian word per element. reply (source) gives one beat per element
// with kind, start address, index, value and a last flag.
// The element beat appears on reply in the cycle after the rx beat that
// completes it. One rx byte is taken per cycle while reply keeps up, set by
// the single parse register stage feeding one output register.
// rx.ready is low only while the output register holds a beat that reply
// does not take; a stalled receiver therefore holds off rx, and nothing is
// dropped. Config writes (cfg_we, cfg_index, cfg_data) set the two header
// bytes and take effect on the next byte.
// Reset puts the parser back to hunting for the first header byte, empties
// the output register and restores the header bytes 0x5A and 0xA5.
`include "assert_macros.svh"

module display_reply_frame_parser_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [drfp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [drfp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    drfp_stream_if.sink                          rx,
    drfp_stream_if.source                        reply
);

    localparam logic [3:0] PH_HUNT1   = 4'd0;
    localparam logic [3:0] PH_HUNT2   = 4'd1;
    localparam logic [3:0] PH_LEN     = 4'd2;
    localparam logic [3:0] PH_CMD     = 4'd3;
    localparam logic [3:0] PH_ADDR_HI = 4'd4;
    localparam logic [3:0] PH_ADDR_LO = 4'd5;
    localparam logic [3:0] PH_COUNT   = 4'd6;
    localparam logic [3:0] PH_DATA_HI = 4'd7;
    localparam logic [3:0] PH_DATA_LO = 4'd8;
    localparam logic [3:0] PH_SKIP    = 4'd9;

    logic [7:0]  header_first_reg;
    logic [7:0]  header_second_reg;

    logic [3:0]  phase_reg,     phase_next;
    logic [7:0]  left_reg,      left_next;
    logic        variable_reg,  variable_next;
    logic [15:0] address_reg,   address_next;
    logic [7:0]  total_reg,     total_next;
    logic [7:0]  position_reg,  position_next;
    logic [7:0]  high_reg,      high_next;

    logic                  out_valid_reg;
    drfp_pkg::reply_beat_t out_data_reg;
    drfp_pkg::reply_beat_t emit_data;
    logic                  emit;

    logic       rx_fire;
    logic [7:0] b;

    assign rx.ready    = !out_valid_reg || reply.ready;
    assign rx_fire     = rx.valid && rx.ready;
    assign b           = rx.data.rx_byte;
    assign reply.valid = out_valid_reg;
    assign reply.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= drfp_pkg::HEADER_FIRST_RESET;
            header_second_reg <= drfp_pkg::HEADER_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                drfp_pkg::CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                drfp_pkg::CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [7:0] left_dec;
        logic [8:0] need;
        logic [7:0] pos_inc;

        left_dec      = left_reg - 8'd1;
        need          = variable_reg ? {b, 1'b0} : {1'b0, b};
        pos_inc       = position_reg + 8'd1;

        phase_next    = phase_reg;
        left_next     = left_reg;
        variable_next = variable_reg;
        address_next  = address_reg;
        total_next    = total_reg;
        position_next = position_reg;
        high_next     = high_reg;
        emit          = 1'b0;

        emit_data.reply_kind    = variable_reg;
        emit_data.start_address = address_reg;
        emit_data.element_index = position_reg;
        emit_data.element_value = variable_reg ? {high_reg, b} : {8'd0, b};
        emit_data.last_element  = (pos_inc == total_reg);

        case (phase_reg)
            PH_HUNT2:
            begin
                if (b == header_second_reg)
                    phase_next = PH_LEN;
                else if (b != header_first_reg)
                    phase_next = PH_HUNT1;
            end
            PH_LEN:
            begin
                left_next  = b;
                phase_next = (b == 8'd0) ? PH_HUNT1 : PH_CMD;
            end
            PH_CMD, PH_ADDR_HI, PH_ADDR_LO, PH_COUNT, PH_DATA_HI, PH_DATA_LO, PH_SKIP:
            begin
                left_next = left_dec;
                case (phase_reg)
                    PH_CMD:
                    begin
                        address_next = 16'd0;
                        if (b == drfp_pkg::CMD_REG_READ)
                        begin
                            variable_next = 1'b0;
                            phase_next    = PH_ADDR_LO;
                        end
                        else if (b == drfp_pkg::CMD_VAR_READ)
                        begin
                            variable_next = 1'b1;
                            phase_next    = PH_ADDR_HI;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                    PH_ADDR_HI:
                    begin
                        address_next = {b, 8'd0};
                        phase_next   = PH_ADDR_LO;
                    end
                    PH_ADDR_LO:
                    begin
                        address_next = {address_reg[15:8], address_reg[7:0] | b};
                        phase_next   = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        total_next    = b;
                        position_next = 8'd0;
                        // drop the frame when the count is zero or the elements overrun its end
                        if (b == 8'd0 || need > {1'b0, left_dec})
                            phase_next = PH_SKIP;
                        else
                            phase_next = PH_DATA_HI;
                    end
                    PH_DATA_HI:
                    begin
                        if (variable_reg)
                        begin
                            high_next  = b;
                            phase_next = PH_DATA_LO;
                        end
                        else
                        begin
                            emit          = 1'b1;
                            position_next = pos_inc;
                            if (pos_inc == total_reg)
                                phase_next = PH_SKIP;
                        end
                    end
                    PH_DATA_LO:
                    begin
                        emit          = 1'b1;
                        position_next = pos_inc;
                        phase_next    = (pos_inc == total_reg) ? PH_SKIP : PH_DATA_HI;
                    end
                    default: ;
                endcase
                if (left_dec == 8'd0)
                    phase_next = PH_HUNT1;
            end
            default:
            begin
                phase_next = (b == header_first_reg) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT1;
            left_reg     <= 8'd0;
            variable_reg <= 1'b0;
            address_reg  <= 16'd0;
            total_reg    <= 8'd0;
            position_reg <= 8'd0;
            high_reg     <= 8'd0;
        end
        else if (rx_fire)
        begin
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            variable_reg <= variable_next;
            address_reg  <= address_next;
            total_reg    <= total_next;
            position_reg <= position_next;
            high_reg     <= high_next;
        end
    end

    // load a new beat on an element, otherwise drain once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rx_fire && emit)
            out_valid_reg <= 1'b1;
        else if (reply.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire && emit)
            out_data_reg <= emit_data;
    end

    `DRFP_ASSERT_NOW(a_stall_blocks_rx, out_valid_reg && !reply.ready, !rx.ready, "rx taken while output stalled")
    `DRFP_ASSERT_NOW(a_body_has_bytes, phase_reg != PH_HUNT1 && phase_reg != PH_HUNT2 && phase_reg != PH_LEN, left_reg != 8'd0, "frame phase with no bytes left")
    `DRFP_ASSERT_NOW(a_position_in_range, phase_reg == PH_DATA_HI || phase_reg == PH_DATA_LO, position_reg < total_reg, "element position past count")
    `DRFP_ASSERT_NEXT(a_no_spurious_beat, rx_fire && phase_reg != PH_DATA_HI && phase_reg != PH_DATA_LO, out_valid_reg == $past(out_valid_reg && !reply.ready), "reply beat outside data phase")

endmodule

### verif/display_reply_frame_parser_checker.sv
`timescale 1ns / 100ps

module display_reply_frame_parser_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [drfp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [drfp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                 rx_valid,
    input  logic                                 rx_ready,
    input  drfp_pkg::rx_beat_t                   rx_data,
    input  logic                                 reply_valid,
    input  logic                                 reply_ready,
    input  drfp_pkg::reply_beat_t                reply_data,
    output int                                   fail_count,
    output int                                   replies_pending,
    output int                                   replies_checked
);
    import drfp_pkg::*;

    typedef enum logic [3:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        READ_LENGTH,
        READ_COMMAND,
        ADDR_HIGH,
        ADDR_LOW,
        READ_COUNT,
        DATA_HIGH,
        DATA_LOW,
        SKIP_BODY
    } parse_phase_e;

    logic [7:0]   hdr_first;
    logic [7:0]   hdr_second;
    parse_phase_e phase;
    logic [7:0]   bytes_left;
    logic         is_variable;
    logic [15:0]  base_address;
    logic [7:0]   element_count;
    logic [7:0]   element_pos;
    logic [7:0]   high_byte;

    reply_beat_t expected_elements[$];

    task automatic push_element(input logic [15:0] value);
        reply_beat_t beat;
        beat.reply_kind    = is_variable;
        beat.start_address = base_address;
        beat.element_index = element_pos;
        beat.element_value = value;
        beat.last_element  = (element_pos + 8'd1) == element_count;
        expected_elements.push_back(beat);
        element_pos = element_pos + 8'd1;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [8:0] need;
        case (phase)
            HUNT_FIRST:
                phase = (b == hdr_first) ? HUNT_SECOND : HUNT_FIRST;
            HUNT_SECOND:
            begin
                // a repeated first header byte keeps waiting for the second
                if (b == hdr_second)
                    phase = READ_LENGTH;
                else if (b != hdr_first)
                    phase = HUNT_FIRST;
            end
            READ_LENGTH:
            begin
                bytes_left = b;
                phase = (b == 8'd0) ? HUNT_FIRST : READ_COMMAND;
            end
            default:
            begin
                bytes_left = bytes_left - 8'd1;
                case (phase)
                    READ_COMMAND:
                    begin
                        base_address = '0;
                        if (b == CMD_REG_READ)
                        begin
                            is_variable = 1'b0;
                            phase = ADDR_LOW;
                        end
                        else if (b == CMD_VAR_READ)
                        begin
                            is_variable = 1'b1;
                            phase = ADDR_HIGH;
                        end
                        else
                            phase = SKIP_BODY;
                    end
                    ADDR_HIGH:
                    begin
                        base_address = {b, 8'h00};
                        phase = ADDR_LOW;
                    end
                    ADDR_LOW:
                    begin
                        base_address[7:0] = b;
                        phase = READ_COUNT;
                    end
                    READ_COUNT:
                    begin
                        element_count = b;
                        element_pos   = '0;
                        need = is_variable ? {b, 1'b0} : {1'b0, b};
                        // drop the elements when the count is zero or they cannot fit in the frame
                        if (b == 8'd0 || need > {1'b0, bytes_left})
                            phase = SKIP_BODY;
                        else
                            phase = DATA_HIGH;
                    end
                    DATA_HIGH:
                    begin
                        if (is_variable)
                        begin
                            high_byte = b;
                            phase = DATA_LOW;
                        end
                        else
                        begin
                            push_element({8'h00, b});
                            if (element_pos == element_count)
                                phase = SKIP_BODY;
                        end
                    end
                    DATA_LOW:
                    begin
                        push_element({high_byte, b});
                        phase = (element_pos == element_count) ? SKIP_BODY : DATA_HIGH;
                    end
                    default:
                        ;
                endcase
                if (bytes_left == 8'd0)
                    phase = HUNT_FIRST;
            end
        endcase
    endtask

    task automatic compare_element(input reply_beat_t got);
        reply_beat_t want;
        if (expected_elements.size() == 0)
        begin
            $error("reply beat with no element expected: index %0d value %0h",
                   got.element_index, got.element_value);
            fail_count++;
            return;
        end
        want = expected_elements.pop_front();
        replies_checked++;
        if (got.reply_kind !== want.reply_kind)
        begin
            $error("reply_kind: expected %0h, got %0h", want.reply_kind, got.reply_kind);
            fail_count++;
        end
        if (got.start_address !== want.start_address)
        begin
            $error("start_address: expected %0h, got %0h",
                   want.start_address, got.start_address);
            fail_count++;
        end
        if (got.element_index !== want.element_index)
        begin
            $error("element_index: expected %0d, got %0d",
                   want.element_index, got.element_index);
            fail_count++;
        end
        if (got.element_value !== want.element_value)
        begin
            $error("element_value: expected %0h, got %0h",
                   want.element_value, got.element_value);
            fail_count++;
        end
        if (got.last_element !== want.last_element)
        begin
            $error("last_element: expected %0h, got %0h", want.last_element, got.last_element);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count      = 0;
        replies_checked = 0;
        replies_pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first     = HEADER_FIRST_RESET;
            hdr_second    = HEADER_SECOND_RESET;
            phase         = HUNT_FIRST;
            bytes_left    = '0;
            is_variable   = 1'b0;
            base_address  = '0;
            element_count = '0;
            element_pos   = '0;
            high_byte     = '0;
            expected_elements.delete();
            replies_pending <= 0;
        end
        else
        begin
            // retire the output beat first: a beat accepted now never
            // belongs to the rx byte taken at this same edge
            if (reply_valid && reply_ready)
                compare_element(reply_data);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEADER_FIRST:  hdr_first  = cfg_data;
                    CFG_HEADER_SECOND: hdr_second = cfg_data;
                    default:           ;
                endcase
            end
            if (rx_valid && rx_ready)
                parse_byte(rx_data.rx_byte);
            replies_pending <= expected_elements.size();
        end
    end

endmodule

### verif/tb_display_reply_frame_parser_unit.sv
`timescale 1ns / 100ps

module tb_display_reply_frame_parser_unit;
    import drfp_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    int fail_count;
    int replies_pending;
    int replies_checked;

    logic [7:0] hdr_first;
    logic [7:0] hdr_second;
    bit         no_idle;
    int         bytes_sent;
    int         frames_sent;
    int         header_settings;

    // repeated first header with zero length, register read with a trailing
    // byte, variable read, body ending before the count, count too large,
    // zero count, unknown command
    logic [7:0] opening_bytes[] = '{
        8'h5A, 8'h5A, 8'hA5, 8'h00,
        8'h5A, 8'hA5, 8'h06, 8'h81, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h3C,
        8'h5A, 8'hA5, 8'h06, 8'h83, 8'h00, 8'h00, 8'h01, 8'h80, 8'h01,
        8'h5A, 8'hA5, 8'h02, 8'h83, 8'h12,
        8'h5A, 8'hA5, 8'h04, 8'h83, 8'h12, 8'h34, 8'h02,
        8'h5A, 8'hA5, 8'h04, 8'h81, 8'h01, 8'h00, 8'h77,
        8'h5A, 8'hA5, 8'h02, 8'h42, 8'h00
    };

    drfp_stream_if #(.payload_t(rx_beat_t))    rx_if ();
    drfp_stream_if #(.payload_t(reply_beat_t)) reply_if ();

    display_reply_frame_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_if),
        .reply     (reply_if)
    );

    display_reply_frame_parser_checker reply_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rx_valid        (rx_if.valid),
        .rx_ready        (rx_if.ready),
        .rx_data         (rx_if.data),
        .reply_valid     (reply_if.valid),
        .reply_ready     (reply_if.ready),
        .reply_data      (reply_if.data),
        .fail_count      (fail_count),
        .replies_pending (replies_pending),
        .replies_checked (replies_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Called right after clk rises; returns once the beat has been taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= rx_beat_t'(b);
        do
            @(posedge clk);
        while (!rx_if.ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] body[$]);
        if ($urandom_range(0, 9) == 0)
            send_byte(hdr_first);
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(8'(body.size()));
        foreach (body[i])
            send_byte(body[i]);
        frames_sent++;
    endtask

    task automatic send_read_frame(input bit is_var, input logic [7:0] count_field,
                                   input int fill, input int trail);
        logic [7:0] body[$];
        body.push_back(is_var ? CMD_VAR_READ : CMD_REG_READ);
        if (is_var)
            body.push_back(rand_byte());
        body.push_back(rand_byte());
        body.push_back(count_field);
        repeat (fill + trail) body.push_back(rand_byte());
        send_frame(body);
    endtask

    task automatic send_random_frame();
        logic [7:0] body[$];
        logic [7:0] cmd;
        int         roll;
        int         width;
        int         count;
        int         trail;
        bit         is_var;
        roll   = $urandom_range(0, 99);
        is_var = $urandom_range(0, 1);
        width  = is_var ? 2 : 1;
        count  = ($urandom_range(0, 29) == 0) ? $urandom_range(9, is_var ? 60 : 120)
                                              : $urandom_range(1, 8);
        trail  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (roll < 68)
            send_read_frame(is_var, 8'(count), count * width, trail);
        else if (roll < 75)
            send_read_frame(is_var, 8'd0, 0, $urandom_range(0, 3));
        else if (roll < 82)
            send_read_frame(is_var, 8'(count), $urandom_range(0, count * width - 1), 0);
        else if (roll < 87)
        begin
            // cut the frame before its count byte
            body.push_back(is_var ? CMD_VAR_READ : CMD_REG_READ);
            repeat ($urandom_range(0, width)) body.push_back(rand_byte());
            send_frame(body);
        end
        else if (roll < 92)
        begin
            do
                cmd = rand_byte();
            while (cmd == CMD_REG_READ || cmd == CMD_VAR_READ);
            body.push_back(cmd);
            repeat ($urandom_range(0, 8)) body.push_back(rand_byte());
            send_frame(body);
        end
        else if (roll < 95)
            send_frame(body);
        else
        begin
            repeat ($urandom_range(1, 6)) send_byte(rand_byte());
            send_byte(hdr_first);
            send_byte(rand_byte());
        end
    endtask

    task automatic run_random(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target)
            send_random_frame();
    endtask

    task automatic settle();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (replies_pending != 0)
            @(posedge clk);
        // rx is idle here, so a partly parsed frame does not move on before the headers change
        repeat (4) @(posedge clk);
    endtask

    task automatic write_headers(input logic [7:0] first, input logic [7:0] second);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEADER_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= CFG_HEADER_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        cfg_we <= 1'b0;
        hdr_first  = first;
        hdr_second = second;
        header_settings++;
    endtask

    initial
    begin : reply_sink
        int stall;
        reply_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            reply_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                reply_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[display_reply_frame_parser_unit] ERROR");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_HEADER_FIRST;
        cfg_data    <= '0;
        rx_if.valid <= 1'b0;
        rx_if.data  <= '0;
        no_idle         = 1'b0;
        bytes_sent      = 0;
        frames_sent     = 0;
        header_settings = 1;
        hdr_first       = HEADER_FIRST_RESET;
        hdr_second      = HEADER_SECOND_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        run_random(50);

        settle();
        write_headers(8'h00, 8'hFF);
        send_read_frame(1'b0, 8'd40, 40, 0);
        run_random(45);

        // back-to-back traffic on both sides
        settle();
        write_headers(8'hFF, 8'h00);
        no_idle = 1'b1;
        send_read_frame(1'b1, 8'd30, 60, 0);
        run_random(45);
        no_idle = 1'b0;

        settle();
        write_headers(8'h3C, 8'h3C);
        run_random(35);

        settle();
        write_headers(HEADER_FIRST_RESET, HEADER_SECOND_RESET);
        run_random(35);

        settle();
        repeat (10) @(posedge clk);
        $display("Fed %0d rx bytes (%0d generated frames) under %0d header settings.",
                 bytes_sent, frames_sent, header_settings);
        $display("Compared %0d element beats with %0d mismatches.",
                 replies_checked, fail_count);
        if (fail_count == 0)
            $display("[display_reply_frame_parser_unit] OK");
        else
            $display("[display_reply_frame_parser_unit] ERROR");
        $finish;
    end

endmodule
